@@ rtl/vector_axis_rotation_top_macros.svh @@
// Assertion helpers for the rotation block.
// VROT_ASSERT runs with reset as a disable; VROT_ASSERT_RST also checks during reset.
`ifndef VECTOR_AXIS_ROTATION_TOP_MACROS_SVH
`define VECTOR_AXIS_ROTATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VROT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vrot check failed");
`define VROT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vrot reset check failed");
`else
`define VROT_ASSERT(label, prop)
`define VROT_ASSERT_RST(label, prop)
`endif
`endif

@@ rtl/vrot_pkg.sv @@
`timescale 1ns / 1ps

package vrot_pkg;

  // Rotation axis codes; the fourth code passes the point through.
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  localparam int TRIG_BITS  = 16;     // signed Q1.15 sine/cosine
  localparam int SINE_AMP   = 32767;  // full-scale table amplitude
  localparam int FRAC_BITS  = 15;     // fraction bits dropped after the multiply
  localparam int ROUND_BIAS = 16384;  // half an LSB of the result

endpackage

@@ rtl/vrot_sincos.sv @@
`timescale 1ns / 1ps

// Quarter-wave sine ROM, read at two addresses (sine and cosine) per cycle while en is high.
module vrot_sincos
  import vrot_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [TRIG_BITS-1:0] sin_val,
  output logic signed [TRIG_BITS-1:0] cos_val
);

  localparam int QBITS = ANGLE_BITS - 2;
  localparam int DEPTH = (2 ** QBITS) + 1;
  localparam int AW    = QBITS + 1;
  localparam real HALF_PI = 1.5707963267948966;
  localparam real QSTEPS  = 2.0 ** QBITS;
  localparam logic [AW-1:0] QUARTER = AW'(1) << QBITS;

  typedef logic [TRIG_BITS-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    real  ph;
    for (int i = 0; i < DEPTH; i++) begin
      ph   = HALF_PI * real'(i) / QSTEPS;
      t[i] = TRIG_BITS'($rtoi(real'(SINE_AMP) * $sin(ph) + 0.5));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [1:0]           quad_s;
  logic [1:0]           quad_c;
  logic [AW-1:0]        r_ext;
  logic [AW-1:0]        sin_addr;
  logic [AW-1:0]        cos_addr;
  logic [TRIG_BITS-1:0] sin_mag;
  logic [TRIG_BITS-1:0] cos_mag;
  logic                 sin_neg;
  logic                 cos_neg;

  // cosine is the sine one quadrant later
  always_comb begin
    quad_s   = angle[ANGLE_BITS-1 -: 2];
    quad_c   = quad_s + 2'd1;
    r_ext    = {1'b0, angle[QBITS-1:0]};
    sin_addr = quad_s[0] ? (QUARTER - r_ext) : r_ext;
    cos_addr = quad_c[0] ? (QUARTER - r_ext) : r_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag <= SINE_ROM[sin_addr];
      cos_mag <= SINE_ROM[cos_addr];
      sin_neg <= quad_s[1];
      cos_neg <= quad_c[1];
    end
  end

  assign sin_val = sin_neg ? -$signed(sin_mag) : $signed(sin_mag);
  assign cos_val = cos_neg ? -$signed(cos_mag) : $signed(cos_mag);

endmodule

@@ rtl/vrot_mul.sv @@
`timescale 1ns / 1ps

// Picks the two in-plane coordinates and registers the four products.
module vrot_mul
  import vrot_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  axis_t                                  axis,
  input  logic signed [COORD_BITS-1:0]           x,
  input  logic signed [COORD_BITS-1:0]           y,
  input  logic signed [COORD_BITS-1:0]           z,
  input  logic signed [TRIG_BITS-1:0]            sin_val,
  input  logic signed [TRIG_BITS-1:0]            cos_val,
  output logic signed [COORD_BITS+TRIG_BITS-1:0] pc,
  output logic signed [COORD_BITS+TRIG_BITS-1:0] qs,
  output logic signed [COORD_BITS+TRIG_BITS-1:0] ps,
  output logic signed [COORD_BITS+TRIG_BITS-1:0] qc
);

  localparam int PW = COORD_BITS + TRIG_BITS;

  logic signed [COORD_BITS-1:0] p;
  logic signed [COORD_BITS-1:0] q;
  logic signed [PW-1:0]         pc_next;
  logic signed [PW-1:0]         qs_next;
  logic signed [PW-1:0]         ps_next;
  logic signed [PW-1:0]         qc_next;

  always_comb begin
    case (axis)
      AXIS_X: begin
        p = y;
        q = z;
      end
      AXIS_Y: begin
        p = x;
        q = z;
      end
      default: begin
        p = x;
        q = y;
      end
    endcase
    pc_next = PW'(p) * PW'(cos_val);
    qs_next = PW'(q) * PW'(sin_val);
    ps_next = PW'(p) * PW'(sin_val);
    qc_next = PW'(q) * PW'(cos_val);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc <= pc_next;
      qs <= qs_next;
      ps <= ps_next;
      qc <= qc_next;
    end
  end

endmodule

@@ rtl/vrot_sat.sv @@
`timescale 1ns / 1ps

// Round to nearest (floor of sum plus half), drop Q15 fraction, clamp.
module vrot_sat
  import vrot_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS+TRIG_BITS:0] sum,
  output logic signed [COORD_BITS-1:0]         val,
  output logic                                 clip
);

  localparam int W  = COORD_BITS + TRIG_BITS + 1;
  localparam int QW = W - FRAC_BITS;
  localparam int HW = QW - COORD_BITS + 1;

  logic signed [W-1:0]          biased;
  logic [HW-1:0]                top_bits;
  logic                         in_range;
  logic signed [COORD_BITS-1:0] lim;

  always_comb begin
    biased   = sum + W'(ROUND_BIAS);
    top_bits = biased[W-1 -: HW];
    in_range = (top_bits == '0) || (top_bits == '1);
    lim      = biased[W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                           : {1'b0, {(COORD_BITS-1){1'b1}}};
    val      = in_range ? biased[FRAC_BITS +: COORD_BITS] : lim;
    clip     = !in_range;
  end

endmodule

@@ rtl/vector_axis_rotation_top.sv @@
`timescale 1ns / 1ps

// Rotates a signed fixed-point 3D point about the x, y or z axis by an angle
// given in 1/2^ANGLE_BITS of a full turn. Sine and cosine are Q1.15 values
// round(32767*sin) from a quarter-wave ROM, and each rotated coordinate is
// (c1*m1 +/- c2*m2 + 16384) >>> 15, clamped to the signed COORD_BITS range;
// clipped flags any clamp. Axis code 3 passes the point through unflagged.
// A beat is accepted every cycle unless in_stall is high; each passes from input
// to output through the registered ROM read (two read ports, sine and cosine), the
// product register, and the rounded, saturated output register. Backpressure
// on the output propagates stage by stage, so bubbles are squeezed out and
// in_stall rises only when all three stages hold a beat and the output stalls.
module vector_axis_rotation_top
  import vrot_pkg::*;
#(
  parameter int ANGLE_BITS = 12,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   axis_sel,
  input  logic [ANGLE_BITS-1:0]        turn_angle,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] rot_x,
  output logic signed [COORD_BITS-1:0] rot_y,
  output logic signed [COORD_BITS-1:0] rot_z,
  output logic                         clipped
);

`include "vector_axis_rotation_top_macros.svh"

  localparam int PW = COORD_BITS + TRIG_BITS;
  localparam int W  = PW + 1;

  // stage enables, fed back from the output stall
  logic en1;
  logic en2;
  logic en3;

  // stage 1: ROM read and input capture
  logic                         v1;
  axis_t                        axis1;
  logic signed [COORD_BITS-1:0] x1;
  logic signed [COORD_BITS-1:0] y1;
  logic signed [COORD_BITS-1:0] z1;
  logic signed [TRIG_BITS-1:0]  sin_val;
  logic signed [TRIG_BITS-1:0]  cos_val;

  // stage 2: products
  logic                         v2;
  axis_t                        axis2;
  logic signed [COORD_BITS-1:0] x2;
  logic signed [COORD_BITS-1:0] y2;
  logic signed [COORD_BITS-1:0] z2;
  logic signed [PW-1:0]         pc;
  logic signed [PW-1:0]         qs;
  logic signed [PW-1:0]         ps;
  logic signed [PW-1:0]         qc;

  // stage 3: combine, round, clamp
  logic signed [W-1:0]          sum_p;
  logic signed [W-1:0]          sum_q;
  logic signed [COORD_BITS-1:0] p_sat;
  logic signed [COORD_BITS-1:0] q_sat;
  logic                         p_clip;
  logic                         q_clip;
  logic signed [COORD_BITS-1:0] rot_x_next;
  logic signed [COORD_BITS-1:0] rot_y_next;
  logic signed [COORD_BITS-1:0] rot_z_next;
  logic                         clipped_next;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      axis1 <= axis_t'(axis_sel);
      x1    <= coord_x;
      y1    <= coord_y;
      z1    <= coord_z;
    end
    if (en2) begin
      axis2 <= axis1;
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
    end
    if (en3) begin
      rot_x   <= rot_x_next;
      rot_y   <= rot_y_next;
      rot_z   <= rot_z_next;
      clipped <= clipped_next;
    end
  end

  vrot_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk    (clk),
    .en     (en1),
    .angle  (turn_angle),
    .sin_val(sin_val),
    .cos_val(cos_val)
  );

  vrot_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk    (clk),
    .en     (en2),
    .axis   (axis1),
    .x      (x1),
    .y      (y1),
    .z      (z1),
    .sin_val(sin_val),
    .cos_val(cos_val),
    .pc     (pc),
    .qs     (qs),
    .ps     (ps),
    .qc     (qc)
  );

  // p' = p*C - q*S, q' = p*S + q*C
  assign sum_p = W'(pc) - W'(qs);
  assign sum_q = W'(ps) + W'(qc);

  vrot_sat #(
    .COORD_BITS(COORD_BITS)
  ) u_sat_p (
    .sum (sum_p),
    .val (p_sat),
    .clip(p_clip)
  );

  vrot_sat #(
    .COORD_BITS(COORD_BITS)
  ) u_sat_q (
    .sum (sum_q),
    .val (q_sat),
    .clip(q_clip)
  );

  // put the rotated pair back in place; the axis coordinate passes unchanged
  always_comb begin
    case (axis2)
      AXIS_X: begin
        rot_x_next   = x2;
        rot_y_next   = p_sat;
        rot_z_next   = q_sat;
        clipped_next = p_clip || q_clip;
      end
      AXIS_Y: begin
        rot_x_next   = p_sat;
        rot_y_next   = y2;
        rot_z_next   = q_sat;
        clipped_next = p_clip || q_clip;
      end
      AXIS_Z: begin
        rot_x_next   = p_sat;
        rot_y_next   = q_sat;
        rot_z_next   = z2;
        clipped_next = p_clip || q_clip;
      end
      default: begin
        rot_x_next   = x2;
        rot_y_next   = y2;
        rot_z_next   = z2;
        clipped_next = 1'b0;
      end
    endcase
  end

  // pipeline empties on reset
  `VROT_ASSERT_RST(a_reset_empty, rst |=> !out_valid)
  // input only backs up when every stage is full and the output is stalled
  `VROT_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall)
  // an accepted beat moves through v1, v2 and out_valid to the output if the output keeps moving
  `VROT_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Checks the axis rotation block against a bit-exact predictor. Sine values are
// rebuilt here with integer series arithmetic, so table rounding matches the
// block exactly. Idling, long output holds and full-rate runs are mixed in.
module testbench;
  import vrot_pkg::*;

  localparam int CB          = 16;          // coordinate width
  localparam int AB          = 12;          // angle width
  localparam int QTR         = 1 << (AB - 2);
  localparam int CYCLE_LIMIT = 400000;      // watchdog, well above the slowest run
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // One output beat as the block should produce it.
  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 clip;
  } rot_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           axis_sel;
  logic [AB-1:0]        turn_angle;
  logic signed [CB-1:0] coord_x;
  logic signed [CB-1:0] coord_y;
  logic signed [CB-1:0] coord_z;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CB-1:0] rot_x;
  logic signed [CB-1:0] rot_y;
  logic signed [CB-1:0] rot_z;
  logic                 clipped;

  int          sine_q [0:QTR];    // quarter-wave sine, Q1.15 amplitude 32767
  rot_beat_t   rotated_q [$];     // predicted beats, oldest first
  rot_beat_t   want_beat;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned points_sent;
  int unsigned beats_seen;
  int unsigned clips_seen;
  int unsigned axis_hits [4];
  bit          jitter_on;         // random gaps on both sides
  int unsigned hold_req;          // long output hold, picked up by the receiver
  int unsigned stall_left;

  vector_axis_rotation_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .axis_sel   (axis_sel),
    .turn_angle (turn_angle),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .rot_z      (rot_z),
    .clipped    (clipped)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sine table: Taylor series in Q62 fixed point, then rounded to 32767 scale.
  // ---------------------------------------------------------------------------

  // (a*b) >> 62, kept to 64 bits
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic int quarter_wave(int r);
    logic [63:0] x, x2, term, pos, neg, s46;
    int n;
    x    = mul_q62(HALF_PI_Q62, 64'(r) << (64 - AB));
    x2   = mul_q62(x, x);
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (n = 1; n < 40 && term != 64'd0; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    s46 = (pos - neg) >> 16;
    return int'((s46 * 64'(SINE_AMP) + (64'd1 << 45)) >> 46);
  endfunction

  // full-circle sine by quadrant folding
  function automatic longint sine_at(logic [AB-1:0] a);
    longint v;
    v = a[AB-2] ? longint'(sine_q[QTR - int'(a[AB-3:0])]) : longint'(sine_q[a[AB-3:0]]);
    return a[AB-1] ? -v : v;
  endfunction

  // round half up by floor, then clamp to the signed coordinate range
  function automatic longint round_clamp(longint acc, output logic hit);
    longint q;
    q   = (acc + ROUND_BIAS) >>> FRAC_BITS;
    hit = 1'b0;
    if (q > 32767) begin
      hit = 1'b1;
      q   = 32767;
    end else if (q < -32768) begin
      hit = 1'b1;
      q   = -32768;
    end
    return q;
  endfunction

  function automatic rot_beat_t rotate_point(axis_t ax, logic [AB-1:0] ang,
                                             logic signed [CB-1:0] px,
                                             logic signed [CB-1:0] py,
                                             logic signed [CB-1:0] pz);
    longint c [3];
    longint sn, cs, p, q;
    logic [AB-1:0] ang_c;
    logic h1, h2;
    int ip, iq;
    rot_beat_t r;
    c[0]   = px;
    c[1]   = py;
    c[2]   = pz;
    r.clip = 1'b0;
    if (ax != AXIS_NONE) begin
      // (p,q) is the plane of rotation; the axis coordinate passes through
      ip     = (ax == AXIS_X) ? 1 : 0;
      iq     = (ax == AXIS_Z) ? 1 : 2;
      ang_c  = ang + AB'(QTR);
      sn     = sine_at(ang);
      cs     = sine_at(ang_c);
      p      = c[ip];
      q      = c[iq];
      c[ip]  = round_clamp(p * cs - q * sn, h1);
      c[iq]  = round_clamp(p * sn + q * cs, h2);
      r.clip = h1 | h2;
    end
    r.x = CB'(c[0]);
    r.y = CB'(c[1]);
    r.z = CB'(c[2]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stalls for a randomly drawn length after each beat when jitter is on.
  // A hold request overrides this and is counted down here, cycle by cycle.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall  <= 1'b0;
    stall_left = 0;
  end

  always @(posedge clk) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = jitter_on ? $urandom_range(0, 7) : 0;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [CB-1:0] want,
                             logic signed [CB-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (rotated_q.size() == 0) begin
        $display("%0t: beat with nothing expected, got (%0d, %0d, %0d) clip %0b",
                 $time, rot_x, rot_y, rot_z, clipped);
        fail_count++;
      end else begin
        want_beat = rotated_q.pop_front();
        check_field("rot_x", want_beat.x, rot_x);
        check_field("rot_y", want_beat.y, rot_y);
        check_field("rot_z", want_beat.z, rot_z);
        check_field("clipped", CB'(want_beat.clip), CB'(clipped));
        if (clipped === 1'b1) clips_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, rotated_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the beat is
  // taken. in_valid is only dropped when a gap is drawn, so back-to-back
  // beats never see a low/high pair of writes in one step.
  // ---------------------------------------------------------------------------
  task automatic send_point(axis_t ax, logic [AB-1:0] ang, logic signed [CB-1:0] px,
                            logic signed [CB-1:0] py, logic signed [CB-1:0] pz);
    int unsigned gap;
    gap = jitter_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    axis_sel   <= ax;
    turn_angle <= ang;
    coord_x    <= px;
    coord_y    <= py;
    coord_z    <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotated_q.push_back(rotate_point(ax, ang, px, py, pz));
    points_sent++;
    axis_hits[ax]++;
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // mostly full-range values, with a share of extremes and small magnitudes
  function automatic logic signed [CB-1:0] pick_coord();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return CB'($urandom);
    if (k < 8) begin
      case ($urandom_range(0, 5))
        0: return CB'(-32768);
        1: return CB'(32767);
        2: return CB'(-32767);
        3: return CB'(0);
        4: return CB'(1);
        default: return CB'(-1);
      endcase
    end
    return CB'(int'($urandom_range(0, 400)) - 200);
  endfunction

  // mostly any angle, some near the eighth-turn points
  function automatic logic [AB-1:0] pick_angle();
    if ($urandom_range(0, 4) == 0)
      return AB'($urandom_range(0, 7) * (QTR / 2) + $urandom_range(0, 2) - 1);
    return AB'($urandom);
  endfunction

  task automatic send_random_point();
    send_point(axis_t'($urandom_range(0, 3)), pick_angle(), pick_coord(), pick_coord(),
               pick_coord());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, every axis code, zero angle, quadrant edges and saturation.
  task automatic test_directed();
    jitter_on = 1'b1;
    send_point(AXIS_X,    12'd0,    32767,  -32768, 12345);  // zero angle still scales
    send_point(AXIS_Y,    12'd0,   -32768,     100, 32767);
    send_point(AXIS_Z,    12'd0,        1,      -1,     0);
    send_point(AXIS_NONE, 12'd777,  32767,  -32768,    -1);  // pass-through
    send_point(AXIS_NONE, 12'd0,        0,       0,     0);
    send_point(AXIS_Z,    12'd1024,  1000,    2000,  3000);  // quarter turn
    send_point(AXIS_Z,    12'd2048, -32768, -32768,     5);  // half turn
    send_point(AXIS_X,    12'd3072,     7,  -32768, 32767);
    send_point(AXIS_Y,    12'd4095,  32767,      0, -32768); // largest angle
    send_point(AXIS_Z,    12'd512,   32767,  32767,     0);  // clamps high
    send_point(AXIS_Z,    12'd512,  -32768, -32768,     0);  // clamps low
    send_point(AXIS_X,    12'd1536,     0,   32767, -32768);
    send_point(AXIS_Y,    12'd2560, -32768,      9, 32767);
    send_point(AXIS_Z,    12'd1,        0,   32767,     0);
    send_point(AXIS_X,    12'd1023,  -300,   32767,  32767);
    send_point(AXIS_Y,    12'd1025,  32767,  -4321, 32767);
    send_point(AXIS_X,    12'd2047,   -1,  -32768, -32768);
    send_point(AXIS_Z,    12'd3584,  32767, -32768, -32768);
    send_point(AXIS_Y,    12'd2816, -32768,  32767, -32768);
    send_point(AXIS_X,    12'd3583,  12345,  32767,  32767);
    wait_drained();
  endtask

  // Long random stream; idling switched on and off in stretches.
  task automatic test_random_stream();
    int i;
    for (i = 0; i < 1250; i++) begin
      if (i % 100 == 0) jitter_on = ($urandom_range(0, 3) != 0);
      send_random_point();
    end
    jitter_on = 1'b1;
  endtask

  // Output held for a long stretch while beats keep coming at full rate,
  // so the pipeline fills and in_stall must rise.
  task automatic test_output_hold();
    int i, k;
    for (k = 0; k < 2; k++) begin
      jitter_on = 1'b0;
      hold_req  = 60;
      for (i = 0; i < 40; i++) send_random_point();
      wait_drained();
    end
    jitter_on = 1'b1;
  endtask

  // Short bursts, each followed by a full drain before the next.
  task automatic test_drain_pauses();
    int i, k;
    for (k = 0; k < 5; k++) begin
      for (i = 0; i < 20; i++) send_random_point();
      wait_drained();
    end
  endtask

  // No idling on either side: one beat per clock end to end.
  task automatic test_full_rate();
    int i;
    jitter_on = 1'b0;
    for (i = 0; i < 150; i++) send_random_point();
    wait_drained();
    jitter_on = 1'b1;
  endtask

  initial begin
    int r;
    in_valid   <= 1'b0;
    axis_sel   <= AXIS_X;
    turn_angle <= '0;
    coord_x    <= '0;
    coord_y    <= '0;
    coord_z    <= '0;
    rst        <= 1'b1;
    fail_count  = 0;
    cycle_count = 0;
    points_sent = 0;
    beats_seen  = 0;
    clips_seen  = 0;
    hold_req    = 0;
    jitter_on   = 1'b1;
    axis_hits   = '{default: 0};
    for (r = 0; r <= QTR; r++) sine_q[r] = quarter_wave(r);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_stream();
    test_output_hold();
    test_drain_pauses();
    test_full_rate();

    // settle: wait past the last expected beat, then check that none is still expected
    wait_drained();
    repeat (8) @(posedge clk);
    if (rotated_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, rotated_q.size());
      fail_count++;
    end

    $display("Sent %0d points (axis x/y/z/none: %0d/%0d/%0d/%0d), checked %0d beats.",
             points_sent, axis_hits[0], axis_hits[1], axis_hits[2], axis_hits[3],
             beats_seen);
    $display("Saw %0d saturated results; ran with gaps, long holds and full rate.",
             clips_seen);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ vector_axis_rotation_top.f @@
+incdir+rtl
rtl/vrot_pkg.sv
rtl/vrot_sincos.sv
rtl/vrot_mul.sv
rtl/vrot_sat.sv
rtl/vector_axis_rotation_top.sv
test/testbench.sv
